// ===== rtl/partial_view_register_file_macros.svh =====
// Assertion macros used by the port-level checker of the register file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PARTIAL_VIEW_REGISTER_FILE_MACROS_SVH
`define PARTIAL_VIEW_REGISTER_FILE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PVRF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PVRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pvrf_pkg.sv =====
// Package of the partial view register file: widths, request codes, view codes
// and the id decode functions. No dependencies.
package pvrf_pkg;

  localparam int DATA_WIDTH   = 64;
  localparam int WORD_WIDTH   = 64;  // integer register width, 32..64
  localparam int TYPE_WIDTH   = 2;
  localparam int ID_WIDTH     = 6;
  localparam int NUM_INT      = 17;
  localparam int NUM_FLT      = 8;
  localparam int INT_IDX_W    = $clog2(NUM_INT);
  localparam int FLT_IDX_W    = $clog2(NUM_FLT);

  localparam logic [ID_WIDTH-1:0] NUM_INT_IDS  = ID_WIDTH'(34);
  localparam logic [ID_WIDTH-1:0] FIRST_FLT_ID = ID_WIDTH'(34);
  localparam logic [ID_WIDTH-1:0] LAST_FLT_ID  = ID_WIDTH'(41);
  localparam logic [ID_WIDTH-1:0] FIRST_SEG_ID = ID_WIDTH'(16);
  localparam logic [ID_WIDTH-1:0] FIRST_GPR_ID = ID_WIDTH'(26);

  // Request codes
  localparam logic [TYPE_WIDTH-1:0] REQ_INT_RD = 2'd0;
  localparam logic [TYPE_WIDTH-1:0] REQ_INT_WR = 2'd1;
  localparam logic [TYPE_WIDTH-1:0] REQ_FLT_RD = 2'd2;
  localparam logic [TYPE_WIDTH-1:0] REQ_FLT_WR = 2'd3;

  typedef enum logic [1:0] {
    VIEW_FULL = 2'd0,
    VIEW_LO16 = 2'd1,
    VIEW_LO8  = 2'd2,
    VIEW_HI8  = 2'd3
  } view_t;

  // Map an integer id to its register; ids past the integer range map to 0.
  function automatic logic [INT_IDX_W-1:0] int_reg_of(input logic [ID_WIDTH-1:0] id);
    logic [ID_WIDTH-1:0] off;
    off = '0;
    if (id < FIRST_SEG_ID) begin
      off = {2'b00, id[ID_WIDTH-1:2]};
    end else if (id < FIRST_GPR_ID) begin
      off = ID_WIDTH'(4) + {1'b0, 5'((id - FIRST_SEG_ID) >> 1)};
    end else if (id < NUM_INT_IDS) begin
      off = id - ID_WIDTH'(17);
    end
    return off[INT_IDX_W-1:0];
  endfunction

  // View selected by an integer id.
  function automatic view_t view_of(input logic [ID_WIDTH-1:0] id);
    view_t v;
    v = VIEW_FULL;
    if (id < FIRST_SEG_ID) begin
      v = view_t'(id[1:0]);
    end else if (id < FIRST_GPR_ID) begin
      v = id[0] ? VIEW_LO16 : VIEW_FULL;
    end
    return v;
  endfunction

endpackage

// ===== rtl/pvrf_if.sv =====
// Valid/ready channel interfaces of the register file: request and response.
// Depends on pvrf_pkg for field widths.
interface pvrf_req_if import pvrf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [TYPE_WIDTH-1:0] req_type;
  logic [ID_WIDTH-1:0]   reg_id;
  logic [DATA_WIDTH-1:0] write_data;

  modport source (output valid, req_type, reg_id, write_data, input ready);
  modport sink   (input valid, req_type, reg_id, write_data, output ready);
endinterface

interface pvrf_rsp_if import pvrf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// ===== rtl/partial_view_register_file.sv =====
// Top level of the partial view register file: input stage, register arrays,
// view merge and response register. Depends on pvrf_pkg and pvrf_if.
//
// Usage:
//   req channel: one request per handshake: req_type (integer/float, read/write),
//     reg_id (full register, low 16, low byte or bits 15:8 view, or float
//     register) and write_data.
//   rsp channel: exactly one response per request, in request order; read_data
//     carries the zero-extended view or float bit pattern, and zero for writes
//     and for ids that do not match the request type.
//   Path: a request is held in the input register, then in the response
//     register, whose output is the response.
//   Throughput: one request per cycle with rsp taken; the register arrays are read
//     and written in the same cycle that a request moves from the input register
//     to the response register, so each request sees every earlier write.
//   Reset (rst, synchronous): clears all registers to zero and empties both
//     stages; req.ready is low while rst is high.
//   Stall: a response not taken holds in the response register; the input
//     register still takes one more request, then req.ready drops until rsp
//     is taken.
module partial_view_register_file import pvrf_pkg::*; (
  input logic        clk,
  input logic        rst,
  pvrf_req_if.sink   req,
  pvrf_rsp_if.source rsp
);

  logic [WORD_WIDTH-1:0] int_regs [NUM_INT];
  logic [DATA_WIDTH-1:0] float_regs [NUM_FLT];

  // Input register
  logic                  s1_valid;
  logic [TYPE_WIDTH-1:0] s1_type;
  logic [ID_WIDTH-1:0]   s1_id;
  logic [DATA_WIDTH-1:0] s1_data;

  // Response register
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_data;

  logic                  out_free;
  logic                  advance;
  logic                  is_int;
  logic                  is_flt;
  logic [INT_IDX_W-1:0]  ireg;
  logic [FLT_IDX_W-1:0]  freg;
  logic [ID_WIDTH-1:0]   fdiff;
  view_t                 view;
  logic [WORD_WIDTH-1:0] int_cur;
  logic [WORD_WIDTH-1:0] int_merged;
  logic [DATA_WIDTH-1:0] rd_val;
  logic                  int_we;
  logic                  flt_we;

  // Handshake
  assign out_free  = !out_valid || rsp.ready;
  assign advance   = s1_valid && out_free;
  assign req.ready = !rst && (!s1_valid || out_free);
  assign rsp.valid = out_valid;
  assign rsp.read_data = out_data;

  // Decode the held request
  assign is_int  = s1_id < NUM_INT_IDS;
  assign is_flt  = (s1_id >= FIRST_FLT_ID) && (s1_id <= LAST_FLT_ID);
  assign ireg    = int_reg_of(s1_id);
  assign view    = view_of(s1_id);
  assign fdiff   = s1_id - FIRST_FLT_ID;
  assign freg    = fdiff[FLT_IDX_W-1:0];
  assign int_cur = int_regs[ireg];

  // Read the selected view
  always_comb begin
    rd_val = '0;
    case (s1_type)
      REQ_INT_RD: begin
        if (is_int) begin
          case (view)
            VIEW_LO16: rd_val = DATA_WIDTH'(int_cur[15:0]);
            VIEW_LO8:  rd_val = DATA_WIDTH'(int_cur[7:0]);
            VIEW_HI8:  rd_val = DATA_WIDTH'(int_cur[15:8]);
            default:   rd_val = DATA_WIDTH'(int_cur);
          endcase
        end
      end
      REQ_FLT_RD: begin
        if (is_flt) begin
          rd_val = float_regs[freg];
        end
      end
      default: rd_val = '0;
    endcase
  end

  // Merge write data into the selected view, keep the rest
  always_comb begin
    case (view)
      VIEW_LO16: int_merged = {int_cur[WORD_WIDTH-1:16], s1_data[15:0]};
      VIEW_LO8:  int_merged = {int_cur[WORD_WIDTH-1:8], s1_data[7:0]};
      VIEW_HI8:  int_merged = {int_cur[WORD_WIDTH-1:16], s1_data[7:0], int_cur[7:0]};
      default:   int_merged = s1_data[WORD_WIDTH-1:0];
    endcase
  end

  assign int_we = advance && (s1_type == REQ_INT_WR) && is_int;
  assign flt_we = advance && (s1_type == REQ_FLT_WR) && is_flt;

  // Register arrays
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_INT; i++) int_regs[i] <= '0;
      for (int j = 0; j < NUM_FLT; j++) float_regs[j] <= '0;
    end else begin
      if (int_we) int_regs[ireg] <= int_merged;
      if (flt_we) float_regs[freg] <= s1_data;
    end
  end

  // Input register: load a new request when the stage empties
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_type <= req.req_type;
      s1_id   <= req.reg_id;
      s1_data <= req.write_data;
    end
  end

  // Response register: advance the held request, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= rd_val;
    end
  end

endmodule

// ===== rtl/pvrf_checker.sv =====
// Port-level checker of the partial view register file, bound to the top level.
// Depends on pvrf_pkg and partial_view_register_file_macros.svh.
`include "partial_view_register_file_macros.svh"

module pvrf_port_checker import pvrf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [DATA_WIDTH-1:0] rsp_read_data
);

  logic       req_fire;
  logic       rsp_fire;
  logic [1:0] inflight;
  logic [1:0] inflight_next;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Count requests accepted but not yet answered
  always_comb begin
    inflight_next = inflight;
    if (req_fire && !rsp_fire) inflight_next = inflight + 2'd1;
    if (!req_fire && rsp_fire) inflight_next = inflight - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `PVRF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data), "stalled response changed")
  `PVRF_ASSERT_SAME(a_rsp_latency, $rose(rsp_valid), $past(req_fire, 2), "response without request two cycles earlier")
  `PVRF_ASSERT_SAME(a_no_phantom, inflight == 2'd0, !rsp_valid, "response with no request outstanding")
  `PVRF_ASSERT_SAME(a_full_stall, (inflight == 2'd2) && !rsp_ready, !req_ready, "request taken with both stages full")

endmodule

bind partial_view_register_file pvrf_port_checker u_pvrf_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data)
);

// ===== tb/pvrf_checker.sv =====
`timescale 1ns / 100ps
// Checker for the partial view register file: tracks the register state and
// predicts read_data for every accepted request, then compares every accepted response.
// Depends on pvrf_pkg and the channel interfaces in pvrf_if.
module pvrf_checker import pvrf_pkg::*; (
  input  logic clk,
  input  logic rst,
  pvrf_req_if  req,
  pvrf_rsp_if  rsp,
  output int   mismatch_count,
  output int   outstanding
);

  localparam logic [DATA_WIDTH-1:0] WORD_MASK =
    {DATA_WIDTH{1'b1}} >> (DATA_WIDTH - WORD_WIDTH);

  logic [DATA_WIDTH-1:0] int_file [NUM_INT];
  logic [DATA_WIDTH-1:0] flt_file [NUM_FLT];
  logic [DATA_WIDTH-1:0] expected_reads [$];

  // Split an integer id into its register slot and view.
  function automatic void split_int_id(input logic [ID_WIDTH-1:0] id,
                                       output int unsigned slot, output view_t view);
    if (id < FIRST_SEG_ID) begin
      slot = id / 4;
      case (id % 4)
        0: view = VIEW_FULL;
        1: view = VIEW_LO16;
        2: view = VIEW_LO8;
        default: view = VIEW_HI8;
      endcase
    end else if (id < FIRST_GPR_ID) begin
      slot = 4 + (id - FIRST_SEG_ID) / 2;
      view = (id % 2 == 1) ? VIEW_LO16 : VIEW_FULL;
    end else begin
      slot = 9 + (id - FIRST_GPR_ID);
      view = VIEW_FULL;
    end
  endfunction

  // Apply one request to the tracked state and return its read_data.
  function automatic logic [DATA_WIDTH-1:0] apply_access(
      input logic [TYPE_WIDTH-1:0] kind, input logic [ID_WIDTH-1:0] id,
      input logic [DATA_WIDTH-1:0] data);
    logic [DATA_WIDTH-1:0] cur;
    logic [DATA_WIDTH-1:0] read_val;
    logic [FLT_IDX_W-1:0]  fslot;
    int unsigned           slot;
    view_t                 view;
    logic                  is_int;
    logic                  is_flt;
    read_val = '0;
    is_int   = id < NUM_INT_IDS;
    is_flt   = (id >= FIRST_FLT_ID) && (id <= LAST_FLT_ID);
    fslot    = FLT_IDX_W'(id - FIRST_FLT_ID);
    case (kind)
      REQ_INT_RD: begin
        if (is_int) begin
          split_int_id(id, slot, view);
          cur = int_file[slot];
          case (view)
            VIEW_LO16: read_val = {48'b0, cur[15:0]};
            VIEW_LO8:  read_val = {56'b0, cur[7:0]};
            VIEW_HI8:  read_val = {56'b0, cur[15:8]};
            default:   read_val = cur & WORD_MASK;
          endcase
        end
      end
      REQ_INT_WR: begin
        if (is_int) begin
          split_int_id(id, slot, view);
          cur = int_file[slot];
          case (view)
            VIEW_LO16: cur[15:0] = data[15:0];
            VIEW_LO8:  cur[7:0]  = data[7:0];
            VIEW_HI8:  cur[15:8] = data[7:0];
            default:   cur = data;
          endcase
          int_file[slot] = cur & WORD_MASK;
        end
      end
      REQ_FLT_RD: begin
        if (is_flt) read_val = flt_file[fslot];
      end
      default: begin
        if (is_flt) flt_file[fslot] = data;
      end
    endcase
    return read_val;
  endfunction

  // Retire responses first, then record the new request of this edge.
  always @(posedge clk) begin
    logic [DATA_WIDTH-1:0] want;
    if (rst) begin
      foreach (int_file[i]) int_file[i] = '0;
      foreach (flt_file[i]) flt_file[i] = '0;
      expected_reads.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_reads.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: response with no request pending, read_data %h",
                     $realtime, rsp.read_data);
          mismatch_count++;
        end else begin
          want = expected_reads.pop_front();
          if (rsp.read_data !== want) begin
            if (mismatch_count < 10)
              $display("%0t: read_data mismatch, expected %h got %h",
                       $realtime, want, rsp.read_data);
            mismatch_count++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_reads.push_back(apply_access(req.req_type, req.reg_id, req.write_data));
    end
    outstanding = expected_reads.size();
  end

endmodule

// ===== tb/tb_partial_view_register_file.sv =====
`timescale 1ns / 100ps
// Top of the register file testbench: clock, reset, request and response traffic
// and the verdict. Depends on pvrf_pkg, pvrf_if, the block and pvrf_checker.
module tb_partial_view_register_file;
  import pvrf_pkg::*;

  localparam logic [ID_WIDTH-1:0] ID_EAX    = ID_WIDTH'(0);
  localparam logic [ID_WIDTH-1:0] ID_AX     = ID_WIDTH'(1);
  localparam logic [ID_WIDTH-1:0] ID_AL     = ID_WIDTH'(2);
  localparam logic [ID_WIDTH-1:0] ID_AH     = ID_WIDTH'(3);
  localparam logic [ID_WIDTH-1:0] ID_ESP    = ID_WIDTH'(16);
  localparam logic [ID_WIDTH-1:0] ID_SP     = ID_WIDTH'(17);
  localparam logic [ID_WIDTH-1:0] ID_R7     = ID_WIDTH'(33);
  localparam logic [ID_WIDTH-1:0] ID_F7     = LAST_FLT_ID;
  localparam logic [ID_WIDTH-1:0] ID_TOP    = {ID_WIDTH{1'b1}};
  localparam int                  NUM_RANDOM = 800;

  logic clk = 1'b0;
  logic rst;
  int   mismatch_count;
  int   outstanding;
  bit   sender_idles = 1'b1;
  bit   sink_idles   = 1'b1;
  bit   hold_off_asked = 1'b0;

  pvrf_req_if req_ch ();
  pvrf_rsp_if rsp_ch ();

  partial_view_register_file dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pvrf_checker chk (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #5 clk = ~clk;

  // Offer one request, with an optional idle burst ahead of it; return once accepted.
  task automatic send_req(input logic [TYPE_WIDTH-1:0] kind, input logic [ID_WIDTH-1:0] id,
                          input logic [DATA_WIDTH-1:0] data);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.reg_id     <= id;
    req_ch.write_data <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Build a random request: mostly ids that match the access kind.
  task automatic send_random();
    logic [TYPE_WIDTH-1:0] kind;
    logic [ID_WIDTH-1:0]   id;
    logic [DATA_WIDTH-1:0] data;
    kind = TYPE_WIDTH'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1: id = ID_WIDTH'($urandom_range(0, 63));
      default: begin
        if (kind == REQ_INT_RD || kind == REQ_INT_WR)
          id = ID_WIDTH'($urandom_range(0, NUM_INT_IDS - 1));
        else
          id = ID_WIDTH'($urandom_range(FIRST_FLT_ID, LAST_FLT_ID));
      end
    endcase
    case ($urandom_range(0, 7))
      0: data = '0;
      1: data = '1;
      default: data = {$urandom, $urandom};
    endcase
    send_req(kind, id, data);
  endtask

  // Drive the response side: ready bursts, stall bursts and one long hold-off.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      if (hold_off_asked) begin
        rsp_ch.ready <= 1'b0;
        repeat (64) @(posedge clk);
        hold_off_asked = 1'b0;
      end else if (!sink_idles || $urandom_range(0, 2) != 0) begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Stimulus: reset, directed accesses, random traffic, drain and verdict.
  initial begin
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_INT_RD;
    req_ch.reg_id     <= '0;
    req_ch.write_data <= '0;
    rst               <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full write, then every partial view of the same register.
    send_req(REQ_INT_WR, ID_EAX, '1);
    send_req(REQ_INT_RD, ID_AL, '0);
    send_req(REQ_INT_RD, ID_AH, '0);
    send_req(REQ_INT_RD, ID_AX, '0);
    // View writes merge only their own bits.
    send_req(REQ_INT_WR, ID_AH, 64'h0123_4567_89AB_CD5A);
    send_req(REQ_INT_WR, ID_AL, 64'hFFFF_FFFF_FFFF_FFA5);
    send_req(REQ_INT_RD, ID_EAX, '0);
    send_req(REQ_INT_WR, ID_AX, 64'hDEAD_BEEF_CAFE_1234);
    send_req(REQ_INT_RD, ID_EAX, '0);
    send_req(REQ_INT_WR, ID_SP, 64'h8000_0000_0000_8001);
    send_req(REQ_INT_RD, ID_ESP, '0);
    send_req(REQ_INT_WR, ID_R7, '1);
    send_req(REQ_INT_RD, ID_R7, '0);
    // Float registers at both ends of their range.
    send_req(REQ_FLT_WR, FIRST_FLT_ID, '1);
    send_req(REQ_FLT_WR, ID_F7, 64'h8000_0000_0000_0000);
    send_req(REQ_FLT_RD, FIRST_FLT_ID, '0);
    // Mismatched kinds and unused ids read zero and write nothing.
    send_req(REQ_INT_RD, FIRST_FLT_ID, '0);
    send_req(REQ_INT_WR, ID_F7, '1);
    send_req(REQ_FLT_RD, ID_F7, '0);
    send_req(REQ_FLT_RD, ID_EAX, '0);
    send_req(REQ_FLT_WR, ID_EAX, '0);
    send_req(REQ_INT_RD, ID_EAX, '0);
    send_req(REQ_INT_WR, ID_TOP, '1);
    send_req(REQ_FLT_WR, ID_TOP, '1);
    send_req(REQ_INT_RD, ID_TOP, '0);
    send_req(REQ_FLT_RD, ID_TOP, '0);

    // Back-to-back requests against a long response hold-off.
    sender_idles   = 1'b0;
    hold_off_asked = 1'b1;
    repeat (40) send_random();
    sender_idles = 1'b1;

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - 100) begin
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
      end
      send_random();
    end
    req_ch.valid <= 1'b0;

    // Drain the remaining responses.
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("partial_view_register_file verification clean");
    end else begin
      $display("partial_view_register_file verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("partial_view_register_file verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pvrf_pkg.sv
rtl/pvrf_if.sv
rtl/partial_view_register_file.sv
rtl/pvrf_checker.sv
tb/pvrf_checker.sv
tb/tb_partial_view_register_file.sv
